// ===== rtl/core/ffha_pkg.sv =====
// Package for the first-fit heap allocator: payload structs, status codes,
// controller states and controller/datapath command and status structs.
// No dependencies.
package ffha_pkg;

  // configuration register indexes
  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_HEAP_END  = 1'b1;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_FULL      = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_e;

  typedef struct packed {
    logic          func;
    logic [31:0]   req_size;
    logic [31:0]   req_addr;
  } req_t;

  typedef struct packed {
    logic [31:0] grant_addr;
    logic [2:0]  status;
    logic [31:0] bytes_in_use;
    logic [31:0] bytes_ever_allocated;
    logic [31:0] heap_grown;
    logic [6:0]  used_entries;
    logic [6:0]  free_entries;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MRG_RD,
    S_MRG_EX,
    S_FIT_RD,
    S_FIT_EX,
    S_RM,
    S_INS,
    S_FREE_RD,
    S_FREE_EX,
    S_DONE
  } state_e;

  // Command from controller to datapath.
  typedef struct packed {
    logic capture;    // latch request
    logic mrg_start;  // init merge pass
    logic mrg_rd;     // issue free-table read at scan index
    logic mrg_step;   // consume merge read data
    logic mrg_end;    // write back top, set new count
    logic fit_start;  // reset scan index
    logic fit_rd;     // read free entry at scan index
    logic fit_hit;    // take chunk at scan index
    logic brk_take;   // grow break pointer
    logic rm_step;    // shift one entry down in removal
    logic ins_step;   // one step of sorted insert
    logic frd;        // read used entry at scan index
    logic fhit;       // free a found chunk
    logic scan_next;  // advance scan index
    logic respond;    // drive result
    logic [2:0] status;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic func;
    logic size_zero;
    logic addr_zero;
    logic scan_end;    // scan index reached table count
    logic used_full;
    logic avail_full;
    logic fit_ok;      // read free entry fits
    logic free_match;  // read used entry matches address
    logic brk_ok;
    logic rm_done;
    logic ins_done;
    logic ins_more;    // another queued insert remains
  } sts_t;

endpackage

// ===== rtl/core/first_fit_heap_allocator.sv =====
// First-fit heap allocator: one request in, one result out.
// A zero size or a null free goes straight from decode to the done state; otherwise
// the time grows with each entry merged, scanned or shifted. One item at a time:
// the next item is taken from the cycle the strobe is high. The strobe lasts one
// cycle; the receiver cannot stall.
// Reset clears counts, break pointer and statistics; table memories need none.
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int unsigned MAX_CHUNKS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // controller sequences merge, fit scan, free scan, removal and sorted insert
  ffha_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // datapath holds the tables and statistics
  ffha_dp #(.MaxChunks(MAX_CHUNKS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

endmodule

// ===== rtl/core/ffha_ctrl.sv =====
// Controller state machine of the first-fit heap allocator.
// Depends on ffha_pkg.
module ffha_ctrl import ffha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (start) state_d = S_DECODE;
      S_DECODE: begin
        if (sts_i.func == FUNC_FREE) begin
          state_d = sts_i.addr_zero ? S_DONE : S_FREE_RD;
        end else begin
          state_d = sts_i.size_zero ? S_DONE : S_MRG_RD;
        end
      end
      S_MRG_RD:  state_d = sts_i.scan_end ? S_FIT_RD : S_MRG_EX;
      S_MRG_EX:  state_d = S_MRG_RD;
      S_FIT_RD: begin
        if (sts_i.used_full) state_d = S_DONE;
        else if (sts_i.scan_end) state_d = sts_i.brk_ok ? S_INS : S_DONE;
        else state_d = S_FIT_EX;
      end
      S_FIT_EX:  state_d = sts_i.fit_ok ? S_RM : S_FIT_RD;
      S_RM:      if (sts_i.rm_done) state_d = S_INS;
      S_INS:     if (sts_i.ins_done && !sts_i.ins_more) state_d = S_DONE;
      S_FREE_RD: state_d = sts_i.scan_end ? S_DONE : S_FREE_EX;
      S_FREE_EX: begin
        if (sts_i.free_match) state_d = sts_i.avail_full ? S_DONE : S_RM;
        else state_d = S_FREE_RD;
      end
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // status code is registered at the deciding point in the datapath
  always_comb begin
    cmd_o = '0;
    cmd_o.status = ST_OK;
    case (state_q)
      S_IDLE:    cmd_o.capture = start;
      S_DECODE: begin
        cmd_o.mrg_start = (sts_i.func == FUNC_ALLOC) && !sts_i.size_zero;
        cmd_o.fit_start = sts_i.func == FUNC_FREE;
        if (sts_i.func == FUNC_FREE) begin
          if (sts_i.addr_zero) cmd_o.status = ST_UNKNOWN;
        end else if (sts_i.size_zero) begin
          cmd_o.status = ST_ZERO;
        end
      end
      S_MRG_RD: begin
        cmd_o.mrg_rd    = !sts_i.scan_end;
        cmd_o.mrg_end   = sts_i.scan_end;
        cmd_o.fit_start = sts_i.scan_end;
      end
      S_MRG_EX:  begin cmd_o.mrg_step = 1'b1; cmd_o.scan_next = 1'b1; end
      S_FIT_RD: begin
        cmd_o.fit_rd = !sts_i.scan_end && !sts_i.used_full;
        if (sts_i.used_full) cmd_o.status = ST_FULL;
        else if (sts_i.scan_end) begin
          if (sts_i.brk_ok) cmd_o.brk_take = 1'b1;
          else cmd_o.status = ST_EXHAUSTED;
        end
      end
      S_FIT_EX: begin
        cmd_o.fit_hit   = sts_i.fit_ok;
        cmd_o.scan_next = !sts_i.fit_ok;
      end
      S_RM:      cmd_o.rm_step = 1'b1;
      S_INS:     cmd_o.ins_step = 1'b1;
      S_FREE_RD: begin
        cmd_o.frd = !sts_i.scan_end;
        if (sts_i.scan_end) cmd_o.status = ST_UNKNOWN;
      end
      S_FREE_EX: begin
        cmd_o.fhit      = sts_i.free_match && !sts_i.avail_full;
        cmd_o.scan_next = !sts_i.free_match;
        if (sts_i.free_match && sts_i.avail_full) cmd_o.status = ST_FULL;
      end
      S_DONE:    cmd_o.respond = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/core/ffha_dp.sv =====
// Datapath of the first-fit heap allocator: chunk table memories, counters,
// break pointer, statistics and the result register. Depends on ffha_pkg.
module ffha_dp import ffha_pkg::*; #(
  parameter int unsigned MaxChunks = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  req_t        req_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        done_o,
  output rsp_t        rsp_o
);

  localparam int unsigned IW = $clog2(MaxChunks);
  localparam int unsigned CW = $clog2(MaxChunks + 1);
  localparam logic [CW-1:0] CntMax = CW'(MaxChunks);

  // memories: {start, len}
  logic [63:0] used_mem  [MaxChunks];
  logic [63:0] avail_mem [MaxChunks];

  logic [CW-1:0] used_cnt_q, avail_cnt_q;
  logic [31:0] brk_q, grown_q, ever_q, live_q, end_q;
  req_t        req_q;
  logic [CW-1:0] idx_q;     // scan / shift index
  logic [CW-1:0] top_q;     // merge top index
  logic [63:0] top_ent_q;   // merge top entry
  logic [63:0] rd_q;        // registered read data
  logic [2:0]  status_q;
  logic [31:0] grant_q;

  // pending inserts: alloc one into used, one optional into avail; free one into avail
  logic        ins_avail_q, ins_sel_q;  // sel 0: used, 1: avail
  logic [63:0] ins_used_ent_q, ins_avail_ent_q;
  logic        ins_rd_q;     // shift phase: data read valid
  logic [CW-1:0] ins_pos_q;
  logic        ins_done_q;
  logic        rm_sel_q;     // 0: remove from avail, 1: from used
  logic [CW-1:0] rm_end_q;
  logic        rm_done_q;
  logic        rm_rd_q;

  // merge read / fit / free read port address shared
  logic [IW-1:0] rd_addr;
  logic          rd_avail_en, rd_used_en;

  logic [32:0] top_end, brk_sum, mrg_sum;
  logic [63:0] ins_ent;

  assign top_end = {1'b0, top_ent_q[63:32]} + {1'b0, top_ent_q[31:0]};
  assign mrg_sum = {1'b0, top_ent_q[31:0]} + {1'b0, rd_q[31:0]};
  assign brk_sum = {1'b0, brk_q} + {1'b0, req_q.req_size};
  assign ins_ent = ins_sel_q ? ins_avail_ent_q : ins_used_ent_q;

  always_comb begin
    sts_o            = '0;
    sts_o.func       = req_q.func;
    sts_o.size_zero  = req_q.req_size == '0;
    sts_o.addr_zero  = req_q.req_addr == '0;
    sts_o.scan_end   = idx_q >= (req_q.func == FUNC_FREE ? used_cnt_q : avail_cnt_q);
    sts_o.used_full  = used_cnt_q >= CntMax;
    sts_o.avail_full = avail_cnt_q >= CntMax;
    sts_o.fit_ok     = rd_q[31:0] >= req_q.req_size;
    sts_o.free_match = rd_q[63:32] == req_q.req_addr;
    sts_o.brk_ok     = !(brk_sum > {1'b0, end_q});
    sts_o.rm_done    = rm_done_q;
    sts_o.ins_done   = ins_done_q;
    sts_o.ins_more   = ins_sel_q == 1'b0 && ins_avail_q;
  end

  // read address selection
  always_comb begin
    rd_addr     = idx_q[IW-1:0];
    rd_avail_en = cmd_i.mrg_rd || cmd_i.fit_rd;
    rd_used_en  = cmd_i.frd;
    if (cmd_i.rm_step) begin
      rd_addr     = IW'(idx_q + 1'b1);
      rd_avail_en = !rm_sel_q;
      rd_used_en  = rm_sel_q;
    end
    if (cmd_i.ins_step) begin
      rd_addr     = IW'(idx_q - 1'b1);
      rd_avail_en = ins_sel_q;
      rd_used_en  = !ins_sel_q;
    end
  end

  // memory writes
  logic          wr_avail, wr_used;
  logic [IW-1:0] wr_addr;
  logic [63:0]   wr_data;

  always_comb begin
    wr_avail = 1'b0;
    wr_used  = 1'b0;
    wr_addr  = top_q[IW-1:0];
    wr_data  = top_ent_q;
    if (cmd_i.mrg_step && !(top_end == {1'b0, rd_q[63:32]})) begin
      wr_avail = 1'b1;
    end else if (cmd_i.mrg_end && avail_cnt_q != '0) begin
      wr_avail = 1'b1;
    end else if (cmd_i.rm_step && rm_rd_q) begin
      wr_addr  = idx_q[IW-1:0];
      wr_data  = rd_q;
      wr_avail = !rm_sel_q;
      wr_used  = rm_sel_q;
    end else if (cmd_i.ins_step && ins_rd_q) begin
      wr_addr  = ins_pos_q[IW-1:0];
      wr_data  = (ins_ent[63:32] < rd_q[63:32]) ? rd_q : ins_ent;
      wr_avail = ins_sel_q;
      wr_used  = !ins_sel_q;
    end else if (cmd_i.ins_step && !ins_rd_q && idx_q == '0 && !ins_done_q) begin
      wr_addr  = '0;
      wr_data  = ins_ent;
      wr_avail = ins_sel_q;
      wr_used  = !ins_sel_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_avail) avail_mem[wr_addr] <= wr_data;
    if (wr_used)  used_mem[wr_addr]  <= wr_data;
    if (rd_avail_en) rd_q <= avail_mem[rd_addr];
    else if (rd_used_en) rd_q <= used_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_cnt_q      <= '0;
      avail_cnt_q     <= '0;
      brk_q           <= '0;
      grown_q         <= '0;
      ever_q          <= '0;
      live_q          <= '0;
      end_q           <= '1;
      idx_q           <= '0;
      top_q           <= '0;
      status_q        <= ST_OK;
      grant_q         <= '0;
      ins_avail_q     <= 1'b0;
      ins_sel_q       <= 1'b0;
      ins_rd_q        <= 1'b0;
      ins_done_q      <= 1'b0;
      ins_used_ent_q  <= '0;
      ins_avail_ent_q <= '0;
      ins_pos_q       <= '0;
      rm_done_q       <= 1'b0;
      rm_rd_q         <= 1'b0;
      rm_sel_q        <= 1'b0;
      rm_end_q        <= '0;
      done_o          <= 1'b0;
    end else begin
      done_o <= cmd_i.respond;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_HEAP_BASE) begin
          if (grown_q == '0) brk_q <= cfg_data_i;
        end else begin
          end_q <= cfg_data_i;
        end
      end
      if (cmd_i.capture) begin
        status_q    <= ST_OK;
        grant_q     <= '0;
        idx_q       <= '0;
        ins_avail_q <= 1'b0;
        ins_sel_q   <= 1'b0;
      end
      if (cmd_i.status != ST_OK) status_q <= cmd_i.status;
      if (cmd_i.mrg_start) begin
        top_q <= '0;
        idx_q <= CW'(1);
      end
      if (cmd_i.scan_next) idx_q <= idx_q + 1'b1;
      if (cmd_i.mrg_step) begin
        if (!(top_end == {1'b0, rd_q[63:32]})) top_q <= top_q + 1'b1;
      end
      if (cmd_i.mrg_end && avail_cnt_q != '0) avail_cnt_q <= top_q + 1'b1;
      if (cmd_i.fit_start) idx_q <= '0;
      if (cmd_i.fit_hit) begin
        grant_q         <= rd_q[63:32];
        ins_used_ent_q  <= {rd_q[63:32], req_q.req_size};
        ins_avail_q     <= rd_q[31:0] != req_q.req_size;
        ins_avail_ent_q <= {rd_q[63:32] + req_q.req_size, rd_q[31:0] - req_q.req_size};
        ever_q          <= ever_q + req_q.req_size;
        live_q          <= live_q + req_q.req_size;
        rm_sel_q        <= 1'b0;
        rm_rd_q         <= 1'b0;
        rm_done_q       <= 1'b0;
        rm_end_q        <= avail_cnt_q;
        ins_sel_q       <= 1'b0;
        ins_rd_q        <= 1'b0;
        ins_done_q      <= 1'b0;
      end
      if (cmd_i.fhit) begin
        live_q          <= live_q - rd_q[31:0];
        ins_avail_q     <= 1'b1;
        ins_avail_ent_q <= rd_q;
        rm_sel_q        <= 1'b1;
        rm_rd_q         <= 1'b0;
        rm_done_q       <= 1'b0;
        rm_end_q        <= used_cnt_q;
        ins_sel_q       <= 1'b1;
        ins_rd_q        <= 1'b0;
        ins_done_q      <= 1'b0;
      end
      if (cmd_i.brk_take) begin
        grant_q        <= brk_q;
        brk_q          <= brk_sum[31:0];
        grown_q        <= grown_q + req_q.req_size;
        ever_q         <= ever_q + req_q.req_size;
        live_q         <= live_q + req_q.req_size;
        ins_used_ent_q <= {brk_q, req_q.req_size};
        ins_sel_q      <= 1'b0;
        ins_rd_q       <= 1'b0;
        ins_done_q     <= 1'b0;
        idx_q          <= used_cnt_q;
      end
      // removal: shift entries above idx down one
      if (cmd_i.rm_step && !rm_done_q) begin
        if (rm_rd_q) idx_q <= idx_q + 1'b1;
        if (idx_q + 1'b1 >= rm_end_q) begin
          rm_done_q <= 1'b1;
          rm_rd_q   <= 1'b0;
          if (rm_sel_q) used_cnt_q <= used_cnt_q - 1'b1;
          else avail_cnt_q <= avail_cnt_q - 1'b1;
          idx_q <= rm_sel_q ? avail_cnt_q : used_cnt_q;
        end else begin
          rm_rd_q <= !rm_rd_q;
        end
      end
      // sorted insert: walk down from count, shifting larger starts up
      if (cmd_i.ins_step) begin
        if (ins_done_q) begin
          ins_done_q <= 1'b0;
          ins_sel_q  <= 1'b1;
          ins_rd_q   <= 1'b0;
          idx_q      <= avail_cnt_q;
        end else if (ins_rd_q) begin
          ins_rd_q <= 1'b0;
          if (ins_ent[63:32] < rd_q[63:32]) begin
            idx_q <= idx_q - 1'b1;
          end else begin
            ins_done_q <= 1'b1;
            if (ins_sel_q) avail_cnt_q <= avail_cnt_q + 1'b1;
            else used_cnt_q <= used_cnt_q + 1'b1;
          end
        end else if (idx_q == '0) begin
          ins_done_q <= 1'b1;
          if (ins_sel_q) avail_cnt_q <= avail_cnt_q + 1'b1;
          else used_cnt_q <= used_cnt_q + 1'b1;
        end else begin
          ins_rd_q  <= 1'b1;
          ins_pos_q <= idx_q;
        end
      end
    end
  end

  // request and merge top entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
    if (cmd_i.mrg_start) top_ent_q <= avail_mem[0];
    if (cmd_i.mrg_step) begin
      if (top_end == {1'b0, rd_q[63:32]}) begin
        top_ent_q[31:0] <= mrg_sum[32] ? 32'hFFFF_FFFF : mrg_sum[31:0];
      end else begin
        top_ent_q <= rd_q;
      end
    end
  end

  assign rsp_o.grant_addr           = grant_q;
  assign rsp_o.status               = status_q;
  assign rsp_o.bytes_in_use         = live_q;
  assign rsp_o.bytes_ever_allocated = ever_q;
  assign rsp_o.heap_grown           = grown_q;
  assign rsp_o.used_entries         = 7'(used_cnt_q);
  assign rsp_o.free_entries         = 7'(avail_cnt_q);

endmodule

// ===== bench/tb_first_fit_heap_allocator.sv =====
// Self-checking bench for first_fit_heap_allocator: directed and random
// allocate/free items across several heap windows, checked against a
// cycle-free predictor of the two chunk tables. Depends on ffha_pkg.
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int unsigned CHUNKS = 64;
  localparam int TAB_USED  = 0;
  localparam int TAB_AVAIL = 1;

  // Predict the allocator and hold the results it owes.
  class heap_scoreboard;
    logic [31:0] base_addr, end_addr, brk, grown, ever, live;
    logic [31:0] tab_start[2][CHUNKS];
    logic [31:0] tab_len[2][CHUNKS];
    int          tab_cnt[2];
    rsp_t        pending[$];
    int          errors;

    function void clear();
      base_addr = '0; end_addr = '1; brk = '0;
      grown = '0; ever = '0; live = '0;
      tab_cnt[0] = 0; tab_cnt[1] = 0;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] val);
      if (idx == REG_HEAP_BASE) begin
        base_addr = val;
        // the break follows the base only until the heap has grown
        if (grown == 0) brk = val;
      end else begin
        end_addr = val;
      end
    endfunction

    // Sorted insert; an equal start lands after existing equals.
    function void tab_insert(int t, logic [31:0] s, logic [31:0] l);
      int i;
      i = tab_cnt[t];
      while (i > 0 && s < tab_start[t][i-1]) begin
        tab_start[t][i] = tab_start[t][i-1];
        tab_len[t][i] = tab_len[t][i-1];
        i--;
      end
      tab_start[t][i] = s;
      tab_len[t][i] = l;
      tab_cnt[t]++;
    endfunction

    function void tab_remove(int t, int idx);
      for (int i = idx; i + 1 < tab_cnt[t]; i++) begin
        tab_start[t][i] = tab_start[t][i+1];
        tab_len[t][i] = tab_len[t][i+1];
      end
      tab_cnt[t]--;
    endfunction

    // Coalesce touching free chunks, saturating the merged length.
    function void merge_free();
      int top;
      logic [32:0] sum;
      if (tab_cnt[TAB_AVAIL] == 0) return;
      top = 0;
      for (int i = 1; i < tab_cnt[TAB_AVAIL]; i++) begin
        if ({1'b0, tab_start[TAB_AVAIL][top]} + tab_len[TAB_AVAIL][top] ==
            {1'b0, tab_start[TAB_AVAIL][i]}) begin
          sum = {1'b0, tab_len[TAB_AVAIL][top]} + tab_len[TAB_AVAIL][i];
          tab_len[TAB_AVAIL][top] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end else begin
          top++;
          tab_start[TAB_AVAIL][top] = tab_start[TAB_AVAIL][i];
          tab_len[TAB_AVAIL][top] = tab_len[TAB_AVAIL][i];
        end
      end
      tab_cnt[TAB_AVAIL] = top + 1;
    endfunction

    function status_e do_alloc(logic [31:0] size, output logic [31:0] grant);
      logic [31:0] s, tail;
      grant = '0;
      if (size == 0) return ST_ZERO;
      merge_free();
      if (tab_cnt[TAB_USED] >= CHUNKS) return ST_FULL;
      for (int i = 0; i < tab_cnt[TAB_AVAIL]; i++) begin
        if (tab_len[TAB_AVAIL][i] >= size) begin
          s = tab_start[TAB_AVAIL][i];
          tail = tab_len[TAB_AVAIL][i] - size;
          tab_remove(TAB_AVAIL, i);
          tab_insert(TAB_USED, s, size);
          ever += size;
          live += size;
          if (tail > 0) tab_insert(TAB_AVAIL, s + size, tail);
          grant = s;
          return ST_OK;
        end
      end
      if ({1'b0, brk} + size > {1'b0, end_addr}) return ST_EXHAUSTED;
      tab_insert(TAB_USED, brk, size);
      grant = brk;
      brk += size;
      grown += size;
      ever += size;
      live += size;
      return ST_OK;
    endfunction

    function status_e do_free(logic [31:0] addr);
      if (addr == 0) return ST_UNKNOWN;
      for (int i = 0; i < tab_cnt[TAB_USED]; i++) begin
        if (tab_start[TAB_USED][i] == addr) begin
          if (tab_cnt[TAB_AVAIL] >= CHUNKS) return ST_FULL;
          live -= tab_len[TAB_USED][i];
          tab_insert(TAB_AVAIL, tab_start[TAB_USED][i], tab_len[TAB_USED][i]);
          tab_remove(TAB_USED, i);
          return ST_OK;
        end
      end
      return ST_UNKNOWN;
    endfunction

    // Note an accepted item: advance the model, queue its result.
    function void note_request(req_t r);
      rsp_t        e;
      logic [31:0] g;
      status_e     st;
      g = '0;
      if (r.func == FUNC_ALLOC) st = do_alloc(r.req_size, g);
      else st = do_free(r.req_addr);
      e.grant_addr = g;
      e.status = st;
      e.bytes_in_use = live;
      e.bytes_ever_allocated = ever;
      e.heap_grown = grown;
      e.used_entries = 7'(tab_cnt[TAB_USED]);
      e.free_entries = 7'(tab_cnt[TAB_AVAIL]);
      pending.push_back(e);
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending: %p", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.grant_addr !== e.grant_addr) begin
        $display("%0t: grant_addr exp %h got %h", $time, e.grant_addr, a.grant_addr);
        errors++;
      end
      if (a.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
        errors++;
      end
      if (a.bytes_in_use !== e.bytes_in_use) begin
        $display("%0t: bytes_in_use exp %h got %h", $time, e.bytes_in_use, a.bytes_in_use);
        errors++;
      end
      if (a.bytes_ever_allocated !== e.bytes_ever_allocated) begin
        $display("%0t: bytes_ever_allocated exp %h got %h", $time,
                 e.bytes_ever_allocated, a.bytes_ever_allocated);
        errors++;
      end
      if (a.heap_grown !== e.heap_grown) begin
        $display("%0t: heap_grown exp %h got %h", $time, e.heap_grown, a.heap_grown);
        errors++;
      end
      if (a.used_entries !== e.used_entries) begin
        $display("%0t: used_entries exp %0d got %0d", $time, e.used_entries, a.used_entries);
        errors++;
      end
      if (a.free_entries !== e.free_entries) begin
        $display("%0t: free_entries exp %0d got %0d", $time, e.free_entries, a.free_entries);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        done_o;
  rsp_t        rsp_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = REG_HEAP_BASE;
  logic [31:0] cfg_data_i = '0;

  heap_scoreboard sb = new();
  int  item_no = 0;
  bit  no_idle = 1'b0;
  bit  fill_mode = 1'b1;

  first_fit_heap_allocator u_dut (
    .clk_i, .rst_ni, .start, .busy, .req_i,
    .done_o, .rsp_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Results cannot be held off: check every strobe as it comes.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(rsp_o);
  end

  // Hold start high until the block takes the item, then note it.
  task automatic send_item(req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
    item_no++;
    // drop start for a random gap in about 8 of 100 items
    if (!no_idle && $urandom_range(99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic alloc(logic [31:0] size);
    req_t r;
    r.func = FUNC_ALLOC;
    r.req_size = size;
    r.req_addr = $urandom();
    send_item(r);
  endtask

  task automatic free_at(logic [31:0] addr);
    req_t r;
    r.func = FUNC_FREE;
    r.req_size = $urandom();
    r.req_addr = addr;
    send_item(r);
  endtask

  // Wait for every owed result, let the block settle, then write.
  task automatic write_reg(logic idx, logic [31:0] val);
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 3) return '0;
    if (p < 75) return $urandom_range(1, 256);
    if (p < 92) return $urandom_range(257, 65536);
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_free_addr();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 80 && sb.tab_cnt[TAB_USED] > 0)
      return sb.tab_start[TAB_USED][$urandom_range(sb.tab_cnt[TAB_USED] - 1)];
    if (p < 85) return '0;
    return $urandom();
  endfunction

  // Mix fill and drain stretches so both tables run full and empty.
  task automatic random_items(int n);
    for (int k = 0; k < n; k++) begin
      if (k % 100 == 0) fill_mode = bit'($urandom_range(1));
      no_idle = (item_no >= 700 && item_no < 1000);
      if ($urandom_range(99) < (fill_mode ? 80 : 20)) alloc(pick_size());
      else free_at(pick_free_addr());
    end
  endtask

  initial begin
    sb.clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Base loads the break while nothing has grown; finish at base zero.
    write_reg(REG_HEAP_BASE, 32'h0000_0100);
    write_reg(REG_HEAP_BASE, 32'h0000_0000);
    write_reg(REG_HEAP_END, 32'hFFFF_FFFF);

    // Directed: zero size, grant at address zero, null and unknown free,
    // exhaustion, reuse with a split tail, and merging of touching chunks.
    alloc(32'd0);
    alloc(32'd16);
    free_at(32'd0);
    alloc(32'd32);
    alloc(32'd64);
    alloc(32'd8);
    free_at(32'd16);
    free_at(32'd48);
    free_at(32'hFFFF_FFFF);
    free_at(32'd17);
    alloc(32'd20);
    alloc(32'hFFFF_FFFF);
    alloc(32'd200);
    alloc(32'd4);
    free_at(32'd16);
    alloc(32'd80);
    alloc(32'h8000_0000);
    alloc(32'h7FFF_FFFF);
    alloc(32'd1);
    free_at(32'h8000_0000 - 32'd0);
    free_at(32'd120);
    alloc(32'h5555_5555);
    alloc(32'hAAAA_AAAA);

    random_items(420);

    // No room past the break: only reuse of freed chunks can succeed.
    write_reg(REG_HEAP_END, 32'h0000_0000);
    random_items(400);

    write_reg(REG_HEAP_BASE, 32'hFFFF_FFFF);
    write_reg(REG_HEAP_END, 32'hFFFF_FFFF);
    random_items(400);

    // Leave a small window above the break.
    write_reg(REG_HEAP_BASE, 32'h0000_1000);
    write_reg(REG_HEAP_END, (sb.brk > 32'hFFFF_EFFF) ? 32'hFFFF_FFFF : sb.brk + 32'd4096);
    random_items(460);

    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule
